// ===== rtl/plam_pkg.sv =====
// ----------------------------------------------------------------------------
// plam_pkg
// Shared types and constants of the PCM frame level and activity meter.
// ----------------------------------------------------------------------------
`default_nettype none

package plam_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned LEVEL_W    = 20;

  // The level needs square_sum * 10^12 / 2^30, which equals square_sum * 5^12 / 2^18.
  localparam int unsigned RMS_KW     = 28;
  localparam logic [RMS_KW-1:0] RMS_K = 28'd244140625;
  localparam int unsigned RMS_SHIFT  = 18;

  localparam int unsigned QUOT_W     = 40;
  localparam int unsigned ROOT_W     = 20;
  localparam int unsigned SQRT_ITERS = 20;
  localparam int unsigned REM_W      = 22;

  localparam logic [LEVEL_W-1:0] PPM_MAX   = 20'd1000000;
  localparam logic [THR_W-1:0]   THR_RESET = 16'd120;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_LOAD,
    ST_DIV,
    ST_SQRT_LOAD,
    ST_SQRT,
    ST_OUT
  } plam_state_e;

  typedef struct packed {
    logic accum;
    logic close;
    logic mul_step;
    logic div_load;
    logic div_step;
    logic sqrt_load;
    logic sqrt_step;
    logic out_load;
  } plam_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/plam_ctrl.sv =====
// ----------------------------------------------------------------------------
// plam_ctrl
// Sequencer for the frame-end multiply, divide and square root, plus the
// input and output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module plam_ctrl #(
  parameter int unsigned SW = 43,
  parameter int unsigned DW = 53
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_last_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output plam_pkg::plam_cmd_t     cmd_o
);

  localparam int unsigned CTW = $clog2(DW + 1);

  plam_pkg::plam_state_e state_q, state_d;
  logic [CTW-1:0]        cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic                  in_acc;
  logic                  out_free;
  logic                  step_state;
  logic                  step_done;

  assign in_ready_o = (state_q == plam_pkg::ST_IDLE) | ~in_last_i;
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;

  always_comb begin
    step_state = 1'b0;
    step_done  = 1'b0;
    case (state_q)
      plam_pkg::ST_MUL: begin
        step_state = 1'b1;
        step_done  = (cnt_q == CTW'(SW - 1));
      end
      plam_pkg::ST_DIV: begin
        step_state = 1'b1;
        step_done  = (cnt_q == CTW'(DW - 1));
      end
      plam_pkg::ST_SQRT: begin
        step_state = 1'b1;
        step_done  = (cnt_q == CTW'(plam_pkg::SQRT_ITERS - 1));
      end
      default: begin
        step_state = 1'b0;
        step_done  = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      plam_pkg::ST_IDLE: begin
        if (in_acc && in_last_i) begin
          state_d = plam_pkg::ST_MUL;
        end
      end
      plam_pkg::ST_MUL: begin
        if (step_done) begin
          state_d = plam_pkg::ST_DIV_LOAD;
        end
      end
      plam_pkg::ST_DIV_LOAD: begin
        state_d = plam_pkg::ST_DIV;
      end
      plam_pkg::ST_DIV: begin
        if (step_done) begin
          state_d = plam_pkg::ST_SQRT_LOAD;
        end
      end
      plam_pkg::ST_SQRT_LOAD: begin
        state_d = plam_pkg::ST_SQRT;
      end
      plam_pkg::ST_SQRT: begin
        if (step_done) begin
          state_d = plam_pkg::ST_OUT;
        end
      end
      plam_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = plam_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = plam_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.accum = in_acc;
    cmd_o.close = in_acc & in_last_i;
    case (state_q)
      plam_pkg::ST_MUL:       cmd_o.mul_step  = 1'b1;
      plam_pkg::ST_DIV_LOAD:  cmd_o.div_load  = 1'b1;
      plam_pkg::ST_DIV:       cmd_o.div_step  = 1'b1;
      plam_pkg::ST_SQRT_LOAD: cmd_o.sqrt_load = 1'b1;
      plam_pkg::ST_SQRT:      cmd_o.sqrt_step = 1'b1;
      plam_pkg::ST_OUT:       cmd_o.out_load  = out_free;
      default: begin
        cmd_o.mul_step = 1'b0;
      end
    endcase
  end

  always_comb begin
    cnt_d = (step_state && !step_done) ? cnt_q + CTW'(1) : '0;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= plam_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_busy_no_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != plam_pkg::ST_IDLE && in_valid_i && in_ready_o) |-> !in_last_i)
    else $error("last item accepted while a frame result is in progress");

  a_close_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_last_i) |=> (state_q == plam_pkg::ST_MUL))
    else $error("frame close did not start the multiply phase");

  a_mul_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == plam_pkg::ST_MUL) |-> (cnt_q < CTW'(SW)))
    else $error("multiply step counter ran past the operand width");

endmodule

`default_nettype wire

// ===== rtl/plam_datapath.sv =====
// ----------------------------------------------------------------------------
// plam_datapath
// Frame accumulators, bit-serial multiply, restoring divide, digit-by-digit
// square root, threshold compare and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module plam_datapath #(
  parameter int unsigned MAX_FRAME_SAMPLES = 4096,
  parameter int unsigned CW = 13,
  parameter int unsigned SW = 43,
  parameter int unsigned MW = 28,
  parameter int unsigned DW = 53
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [plam_pkg::THR_W-1:0]           cfg_thr_i,
  input  wire logic signed [plam_pkg::SAMPLE_W-1:0] sample_i,
  input  wire plam_pkg::plam_cmd_t                  cmd_i,
  output logic [plam_pkg::LEVEL_W-1:0]              level_o,
  output logic                                      activity_o
);

  localparam int unsigned PW  = SW + plam_pkg::RMS_KW;
  localparam int unsigned PRW = CW + plam_pkg::THR_W;
  localparam int unsigned QW  = plam_pkg::QUOT_W;
  localparam int unsigned RW  = plam_pkg::ROOT_W;
  localparam int unsigned XW  = plam_pkg::REM_W;

  logic [plam_pkg::THR_W-1:0]    thr_q;
  logic [CW-1:0]                 cnt_acc_q;
  logic [SW-1:0]                 sq_acc_q;
  logic [MW-1:0]                 mag_acc_q;

  logic [plam_pkg::SAMPLE_W-1:0] raw;
  logic [plam_pkg::SAMPLE_W-1:0] mag;
  logic [2*plam_pkg::SAMPLE_W-1:0] sq;
  logic                          can_add;
  logic [CW-1:0]                 cnt_next;
  logic [SW-1:0]                 sq_next;
  logic [MW-1:0]                 mag_next;

  logic [SW-1:0]                 s_q;
  logic [MW-1:0]                 m_q;
  logic [CW-1:0]                 n_q;
  logic [PW-1:0]                 p_q;
  logic [DW-1:0]                 d_q;
  logic [CW-1:0]                 r_q;
  logic [PRW-1:0]                prod_q;
  logic [QW-1:0]                 x_q;
  logic [XW-1:0]                 rem_q;
  logic [RW-1:0]                 root_q;
  logic [plam_pkg::LEVEL_W-1:0]  level_q;
  logic                          act_q;

  logic [PW-1:0]                 p_d;
  logic [CW:0]                   dtrial;
  logic [CW:0]                   ddiff;
  logic                          dge;
  logic [XW+1:0]                 rem_t;
  logic [XW+1:0]                 strial;
  logic [XW+1:0]                 sdiff;
  logic                          sge;

  assign raw      = sample_i;
  assign mag      = raw[plam_pkg::SAMPLE_W-1] ? (~raw + 16'd1) : raw;
  assign sq       = mag * mag;
  assign can_add  = (cnt_acc_q < CW'(MAX_FRAME_SAMPLES));
  assign cnt_next = can_add ? cnt_acc_q + CW'(1) : cnt_acc_q;
  assign sq_next  = can_add ? sq_acc_q + SW'(sq) : sq_acc_q;
  assign mag_next = can_add ? mag_acc_q + MW'(mag) : mag_acc_q;

  assign p_d    = {p_q[PW-2:0], 1'b0} + (s_q[SW-1] ? PW'(plam_pkg::RMS_K) : '0);

  assign dtrial = {r_q, d_q[DW-1]};
  assign dge    = (dtrial >= {1'b0, n_q});
  assign ddiff  = dtrial - {1'b0, n_q};

  assign rem_t  = {rem_q, x_q[QW-1:QW-2]};
  assign strial = (XW+2)'({root_q, 2'b01});
  assign sge    = (rem_t >= strial);
  assign sdiff  = rem_t - strial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= plam_pkg::THR_RESET;
      cnt_acc_q <= '0;
      sq_acc_q  <= '0;
      mag_acc_q <= '0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_thr_i;
      end
      if (cmd_i.close) begin
        cnt_acc_q <= '0;
        sq_acc_q  <= '0;
        mag_acc_q <= '0;
      end else if (cmd_i.accum) begin
        cnt_acc_q <= cnt_next;
        sq_acc_q  <= sq_next;
        mag_acc_q <= mag_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.close) begin
      s_q <= sq_next;
      m_q <= mag_next;
      n_q <= cnt_next;
      p_q <= '0;
    end
    if (cmd_i.mul_step) begin
      p_q <= p_d;
      s_q <= {s_q[SW-2:0], 1'b0};
    end
    if (cmd_i.div_load) begin
      d_q    <= p_q[PW-1:plam_pkg::RMS_SHIFT];
      r_q    <= '0;
      prod_q <= PRW'(thr_q) * PRW'(n_q);
    end
    if (cmd_i.div_step) begin
      r_q <= dge ? ddiff[CW-1:0] : dtrial[CW-1:0];
      d_q <= {d_q[DW-2:0], dge};
    end
    if (cmd_i.sqrt_load) begin
      x_q    <= d_q[QW-1:0];
      rem_q  <= '0;
      root_q <= '0;
    end
    if (cmd_i.sqrt_step) begin
      rem_q  <= sge ? sdiff[XW-1:0] : rem_t[XW-1:0];
      root_q <= {root_q[RW-2:0], sge};
      x_q    <= {x_q[QW-3:0], 2'b00};
    end
    if (cmd_i.out_load) begin
      level_q <= (root_q > plam_pkg::PPM_MAX) ? plam_pkg::PPM_MAX : root_q;
      act_q   <= (PRW'(m_q) >= prod_q);
    end
  end

  assign level_o    = level_q;
  assign activity_o = act_q;

  a_div_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (n_q != '0))
    else $error("divide step with a zero sample count");

  a_rem_below : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |=> (r_q < n_q))
    else $error("divide remainder not below the divisor");

endmodule

`default_nettype wire

// ===== rtl/pcm_frame_level_activity_meter_top.sv =====
// ----------------------------------------------------------------------------
// pcm_frame_level_activity_meter_top
// Frame RMS level in ppm of full scale and mean-magnitude activity detector.
// ----------------------------------------------------------------------------
// Input items carry one signed 16-bit sample and a last-of-frame mark. Output
// items carry the frame level in ppm (0 to 1000000) and the activity flag, one
// per frame. The threshold register is written through its own valid/ready
// channel, which is always ready; write it only while the block is idle.
// Samples that are not last are taken one per cycle at all times. A last
// item starts the frame-end sequence: a bit-serial multiply, the divider load
// and a restoring divide, the root load and a square root, then the output
// load. The square sum is SW = clog2(MAX_FRAME_SAMPLES+1) + 30 bits wide and
// the dividend DW = SW + 10 bits. Samples of the next frame are accumulated
// meanwhile; only its last item waits until the sequencer is idle. A result
// waits in the output register while the receiver stalls, and the sequencer
// holds before loading the next one. Reset clears the accumulators, drops the
// output valid and sets the threshold to 120.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_frame_level_activity_meter_top #(
  parameter int unsigned MAX_FRAME_SAMPLES = 4096
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [plam_pkg::THR_W-1:0]           cfg_activity_threshold_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic signed [plam_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic                                 last_sample_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [plam_pkg::LEVEL_W-1:0]              level_ppm_o,
  output logic                                      activity_o
);

  localparam int unsigned CW = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int unsigned SW = CW + 30;
  localparam int unsigned MW = CW + 15;
  localparam int unsigned DW = SW + plam_pkg::RMS_KW - plam_pkg::RMS_SHIFT;

  plam_pkg::plam_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  plam_ctrl #(
    .SW (SW),
    .DW (DW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (last_sample_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  plam_datapath #(
    .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES),
    .CW                (CW),
    .SW                (SW),
    .MW                (MW),
    .DW                (DW)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_thr_i  (cfg_activity_threshold_i),
    .sample_i   (sample_i),
    .cmd_i      (cmd),
    .level_o    (level_ppm_o),
    .activity_o (activity_o)
  );

endmodule

`default_nettype wire
